/* rtl/core/gms_pkg.sv */
package gms_pkg;

    localparam int MAX_TASKS      = 128;
    localparam int MAX_PROCESSORS = 128;

    localparam int TASK_W  = 16;
    localparam int LOAD_W  = 23;
    localparam int PCFG_W  = 8;

    localparam int TASK_AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TASK_CW = $clog2(MAX_TASKS + 1);
    localparam int PROC_AW = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
    localparam int PROC_CW = $clog2(MAX_PROCESSORS + 1);

    localparam logic [LOAD_W-1:0] LOAD_LIMIT = {LOAD_W{1'b1}};

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_SORT_LD  = 4'd2;
    localparam logic [3:0] ST_SORT_V   = 4'd3;
    localparam logic [3:0] ST_SORT_CMP = 4'd4;
    localparam logic [3:0] ST_SORT_INS = 4'd5;
    localparam logic [3:0] ST_TASK_RD  = 4'd6;
    localparam logic [3:0] ST_SCAN     = 4'd7;
    localparam logic [3:0] ST_WRITE    = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

endpackage

/* rtl/core/gms_ram.sv */
module gms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/greedy_makespan_scheduler.sv */
// Greedy list scheduler, shortest task first. Task durations are loaded one
// transaction per cycle into a task memory; the transaction flagged last_task
// starts the computation and no transaction is taken until it ends. The
// computation clears the processor load memory (P entries, P = clamped
// processor_count), insertion-sorts the N stored tasks in place in the task
// memory (one compare-and-shift per cycle), then places each task on the
// least-loaded processor by scanning the load memory. One result per set:
// the largest load and whether tasks beyond the capacity of 128 were
// dropped. The result sits in an output register; loading of the next set
// may proceed while it waits.
module greedy_makespan_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [gms_pkg::PCFG_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gms_pkg::TASK_W-1:0] task_time,
    input  logic                       last_task,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gms_pkg::LOAD_W-1:0] makespan,
    output logic                       overflow
);

    logic [3:0]                   state_reg, state_next;
    logic [gms_pkg::PCFG_W-1:0]   pcount_reg;
    logic [gms_pkg::TASK_CW-1:0]  count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [gms_pkg::TASK_CW-1:0]  n_reg, n_next;
    logic [gms_pkg::PROC_CW-1:0]  procs_reg, procs_next;
    logic [gms_pkg::TASK_CW-1:0]  i_reg, i_next;
    logic [gms_pkg::TASK_CW-1:0]  j_reg, j_next;
    logic [gms_pkg::TASK_W-1:0]   v_reg, v_next;
    logic [gms_pkg::PROC_CW-1:0]  dp_reg, dp_next;
    logic [gms_pkg::LOAD_W-1:0]   best_val_reg, best_val_next;
    logic [gms_pkg::PROC_AW-1:0]  best_idx_reg, best_idx_next;
    logic [gms_pkg::LOAD_W-1:0]   max_reg, max_next;
    logic                         out_valid_reg, out_valid_next;
    logic [gms_pkg::LOAD_W-1:0]   makespan_reg, makespan_next;
    logic                         overflow_reg, overflow_next;

    logic                         t_we;
    logic [gms_pkg::TASK_AW-1:0]  t_waddr, t_raddr;
    logic [gms_pkg::TASK_W-1:0]   t_wdata, t_rdata;
    logic                         l_we;
    logic [gms_pkg::PROC_AW-1:0]  l_waddr, l_raddr;
    logic [gms_pkg::LOAD_W-1:0]   l_wdata, l_rdata;

    logic                         in_fire;
    logic [gms_pkg::TASK_CW-1:0]  i_inc;
    logic [gms_pkg::PROC_CW-1:0]  dp_inc;
    logic [gms_pkg::PROC_CW-1:0]  procs_clamp;
    logic [gms_pkg::LOAD_W:0]     load_sum;
    logic [gms_pkg::LOAD_W-1:0]   load_new;

    gms_ram #(
        .WIDTH (gms_pkg::TASK_W),
        .DEPTH (gms_pkg::MAX_TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    gms_ram #(
        .WIDTH (gms_pkg::LOAD_W),
        .DEPTH (gms_pkg::MAX_PROCESSORS)
    ) u_load_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    assign in_ready  = (state_reg == gms_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign makespan  = makespan_reg;
    assign overflow  = overflow_reg;

    assign i_inc    = i_reg + gms_pkg::TASK_CW'(1);
    assign dp_inc   = dp_reg + gms_pkg::PROC_CW'(1);
    assign load_sum = {1'b0, best_val_reg} + (gms_pkg::LOAD_W + 1)'(t_rdata);
    assign load_new = load_sum[gms_pkg::LOAD_W] ? gms_pkg::LOAD_LIMIT
                                                : load_sum[gms_pkg::LOAD_W-1:0];

    always_comb
    begin
        if (pcount_reg == '0)
        begin
            procs_clamp = gms_pkg::PROC_CW'(1);
        end
        else if (32'(pcount_reg) > gms_pkg::MAX_PROCESSORS)
        begin
            procs_clamp = gms_pkg::PROC_CW'(gms_pkg::MAX_PROCESSORS);
        end
        else
        begin
            procs_clamp = gms_pkg::PROC_CW'(pcount_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        procs_next     = procs_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        v_next         = v_reg;
        dp_next        = dp_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg && !out_ready;
        makespan_next  = makespan_reg;
        overflow_next  = overflow_reg;

        t_we    = 1'b0;
        t_waddr = count_reg[gms_pkg::TASK_AW-1:0];
        t_wdata = task_time;
        t_raddr = i_reg[gms_pkg::TASK_AW-1:0];
        l_we    = 1'b0;
        l_waddr = dp_reg[gms_pkg::PROC_AW-1:0];
        l_wdata = '0;
        l_raddr = '0;

        case (state_reg)
            gms_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (32'(count_reg) < gms_pkg::MAX_TASKS)
                    begin
                        t_we       = 1'b1;
                        count_next = count_reg + gms_pkg::TASK_CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_task)
                    begin
                        n_next     = count_next;
                        procs_next = procs_clamp;
                        dp_next    = '0;
                        max_next   = '0;
                        state_next = gms_pkg::ST_CLEAR;
                    end
                end
            end

            gms_pkg::ST_CLEAR:
            begin
                l_we    = 1'b1;
                dp_next = dp_inc;
                if (dp_inc == procs_reg)
                begin
                    if (n_reg > gms_pkg::TASK_CW'(1))
                    begin
                        i_next     = gms_pkg::TASK_CW'(1);
                        state_next = gms_pkg::ST_SORT_LD;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = gms_pkg::ST_TASK_RD;
                    end
                end
            end

            gms_pkg::ST_SORT_LD:
            begin
                state_next = gms_pkg::ST_SORT_V;
            end

            gms_pkg::ST_SORT_V:
            begin
                v_next     = t_rdata;
                j_next     = i_reg;
                t_raddr    = gms_pkg::TASK_AW'(i_reg - gms_pkg::TASK_CW'(1));
                state_next = gms_pkg::ST_SORT_CMP;
            end

            gms_pkg::ST_SORT_CMP:
            begin
                t_we    = 1'b1;
                t_waddr = j_reg[gms_pkg::TASK_AW-1:0];
                if (v_reg < t_rdata)
                begin
                    t_wdata = t_rdata;
                    j_next  = j_reg - gms_pkg::TASK_CW'(1);
                    t_raddr = gms_pkg::TASK_AW'(j_reg - gms_pkg::TASK_CW'(2));
                    if (j_reg == gms_pkg::TASK_CW'(1))
                    begin
                        state_next = gms_pkg::ST_SORT_INS;
                    end
                end
                else
                begin
                    t_wdata = v_reg;
                    i_next  = i_inc;
                    if (i_inc == n_reg)
                    begin
                        i_next     = '0;
                        state_next = gms_pkg::ST_TASK_RD;
                    end
                    else
                    begin
                        state_next = gms_pkg::ST_SORT_LD;
                    end
                end
            end

            gms_pkg::ST_SORT_INS:
            begin
                t_we    = 1'b1;
                t_waddr = '0;
                t_wdata = v_reg;
                i_next  = i_inc;
                if (i_inc == n_reg)
                begin
                    i_next     = '0;
                    state_next = gms_pkg::ST_TASK_RD;
                end
                else
                begin
                    state_next = gms_pkg::ST_SORT_LD;
                end
            end

            gms_pkg::ST_TASK_RD:
            begin
                l_raddr    = '0;
                dp_next    = '0;
                state_next = gms_pkg::ST_SCAN;
            end

            gms_pkg::ST_SCAN:
            begin
                l_raddr = dp_inc[gms_pkg::PROC_AW-1:0];
                if ((dp_reg == '0) || (l_rdata < best_val_reg))
                begin
                    best_val_next = l_rdata;
                    best_idx_next = dp_reg[gms_pkg::PROC_AW-1:0];
                end
                dp_next = dp_inc;
                if (dp_inc == procs_reg)
                begin
                    state_next = gms_pkg::ST_WRITE;
                end
            end

            gms_pkg::ST_WRITE:
            begin
                l_we    = 1'b1;
                l_waddr = best_idx_reg;
                l_wdata = load_new;
                if (load_new > max_reg)
                begin
                    max_next = load_new;
                end
                i_next = i_inc;
                if (i_inc == n_reg)
                begin
                    state_next = gms_pkg::ST_DONE;
                end
                else
                begin
                    state_next = gms_pkg::ST_TASK_RD;
                end
            end

            gms_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    makespan_next  = max_reg;
                    overflow_next  = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = gms_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gms_pkg::ST_IDLE;
            pcount_reg    <= gms_pkg::PCFG_W'(1);
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pcount_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        procs_reg    <= procs_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        v_reg        <= v_next;
        dp_reg       <= dp_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        max_reg      <= max_next;
        makespan_reg <= makespan_next;
        overflow_reg <= overflow_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= gms_pkg::MAX_TASKS)
        else $error("task count beyond capacity");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gms_pkg::ST_WRITE) |->
            (gms_pkg::PROC_CW'(best_idx_reg) < procs_reg))
        else $error("selected processor outside active range");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gms_pkg::ST_SORT_CMP) |->
            ((j_reg != '0) && (j_reg <= i_reg) && (i_reg < n_reg)))
        else $error("sort pointer out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == gms_pkg::ST_DONE))
        else $error("result raised outside completion");

endmodule
